FILE: design/pdvc_pkg.sv
// Shared types, constants and the arctangent table for the polar delta vector command unit.
package pdvc_pkg;

    // CORDIC iteration count, one cell per iteration (range 8 to 32)
    localparam int CORDIC_STEPS = 16;
    localparam int SHIFT_W      = 5;
    localparam int XY_W         = 48;
    localparam int Z_W          = 32;

    // configuration register indexes
    localparam logic CFG_GAIN_Z = 1'b0;
    localparam logic CFG_GAIN_Y = 1'b1;

    // degrees scaled by 2^20
    localparam logic signed [Z_W-1:0] DEG_90  = 32'sd94371840;
    localparam logic signed [Z_W-1:0] DEG_180 = 32'sd188743680;
    localparam logic signed [Z_W-1:0] DEG_360 = 32'sd377487360;

    // CORDIC gain compensation, Q30 and Q20
    localparam logic [29:0] K_Q30 = 30'd652032874;
    localparam logic [19:0] K_Q20 = 20'd636751;

    // data handed from cell to cell
    typedef struct packed {
        logic                   valid;
        logic                   vec;   // 1: vectoring, 0: rotation
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cordic;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_ROT,
        ST_GAIN,
        ST_VLAUNCH,
        ST_VEC,
        ST_MAG1,
        ST_MAG2,
        ST_DONE
    } t_state;

    // arctangent of 2^-i in degrees Q20
    function automatic logic signed [Z_W-1:0] atan_q20(input logic [SHIFT_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 32'sd47185920;
            5'd1:    v = 32'sd27855475;
            5'd2:    v = 32'sd14718068;
            5'd3:    v = 32'sd7471121;
            5'd4:    v = 32'sd3750058;
            5'd5:    v = 32'sd1876857;
            5'd6:    v = 32'sd938658;
            5'd7:    v = 32'sd469357;
            5'd8:    v = 32'sd234682;
            5'd9:    v = 32'sd117342;
            5'd10:   v = 32'sd58671;
            5'd11:   v = 32'sd29335;
            5'd12:   v = 32'sd14668;
            5'd13:   v = 32'sd7334;
            5'd14:   v = 32'sd3667;
            5'd15:   v = 32'sd1833;
            5'd16:   v = 32'sd917;
            5'd17:   v = 32'sd458;
            5'd18:   v = 32'sd229;
            5'd19:   v = 32'sd115;
            5'd20:   v = 32'sd57;
            5'd21:   v = 32'sd29;
            5'd22:   v = 32'sd14;
            5'd23:   v = 32'sd7;
            5'd24:   v = 32'sd4;
            5'd25:   v = 32'sd2;
            5'd26:   v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/pdvc_cell.sv
// One CORDIC micro-rotation cell, shared by rotation and vectoring passes.
module pdvc_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [pdvc_pkg::SHIFT_W-1:0]     i_shift,
    input  logic signed [pdvc_pkg::Z_W-1:0]  i_atan,
    input  pdvc_pkg::t_cordic                i_data,
    output pdvc_pkg::t_cordic                o_data
);
    import pdvc_pkg::*;

    t_cordic                r_out;
    t_cordic                n_out;
    logic signed [XY_W-1:0] sx;
    logic signed [XY_W-1:0] sy;
    logic                   dir;

    // direction: rotation follows z sign, vectoring drives y to zero
    always_comb begin
        sx  = i_data.x >>> i_shift;
        sy  = i_data.y >>> i_shift;
        dir = i_data.vec ? i_data.y[XY_W-1] : !i_data.z[Z_W-1];
        n_out       = i_data;
        if (dir) begin
            n_out.x = i_data.x - sy;
            n_out.y = i_data.y + sx;
            n_out.z = i_data.z - i_atan;
        end else begin
            n_out.x = i_data.x + sy;
            n_out.y = i_data.y - sx;
            n_out.z = i_data.z + i_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule

FILE: design/pdvc_chain.sv
// Row of CORDIC cells, one per iteration, each with its own shift and arctangent step.
module pdvc_chain (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pdvc_pkg::t_cordic i_data,
    output pdvc_pkg::t_cordic o_data
);
    import pdvc_pkg::*;

    t_cordic link [CORDIC_STEPS+1];

    assign link[0] = i_data;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        pdvc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (SHIFT_W'(g)),
            .i_atan  (atan_q20(SHIFT_W'(g))),
            .i_data  (link[g]),
            .o_data  (link[g+1])
        );
    end

    assign o_data = link[CORDIC_STEPS];

endmodule

FILE: design/polar_delta_vector_command_unit.sv
// Polar delta vector command unit: top level with sequencer, gain scaling and result stage.
// One beat in gives one beat out. An item takes a pass through the
// 16-cell CORDIC chain to resolve Y/Z, the gain multiply, a second pass through the
// same chain in vectoring mode, and a split multiply for the magnitude (MAG1, MAG2).
// The chain is the pacing resource and serves one item at a time; a zero difference
// vector skips the vectoring pass. A finished result waits in an output register, and
// the next beat is taken while it waits.
module polar_delta_vector_command_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [15:0] signal_magnitude, [31:16] roll_degrees
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata   // [19:0] command_magnitude, [34:20] command_angle
);
    import pdvc_pkg::*;

    t_state r_state;
    t_state n_state;

    logic signed [15:0] r_gain_z;
    logic signed [15:0] r_gain_y;
    logic signed [23:0] r_prev_y;
    logic signed [23:0] r_prev_z;

    logic signed [XY_W-1:0] r_x0;
    logic signed [Z_W-1:0]  r_z0;
    logic signed [24:0]     r_dy;
    logic signed [24:0]     r_dz;
    logic signed [40:0]     r_ay;
    logic signed [40:0]     r_az;
    logic signed [XY_W-1:0] r_vx;
    logic signed [Z_W-1:0]  r_vz;
    logic [43:0]            r_plo;
    logic [43:0]            r_phi;
    logic [19:0]            r_res_mag;
    logic [14:0]            r_res_ang;
    logic                   r_out_valid;
    logic [19:0]            r_out_mag;
    logic [14:0]            r_out_ang;

    t_cordic chain_in;
    t_cordic chain_out;

    logic                   in_acc;
    logic signed [Z_W-1:0]  theta;
    logic signed [Z_W-1:0]  theta_w;
    logic signed [Z_W-1:0]  theta_f;
    logic                   flip;
    logic signed [45:0]     prod_mk;
    logic signed [XY_W-1:0] rx_full;
    logic signed [23:0]     ty;
    logic signed [23:0]     tz;
    logic                   vec_zero;
    logic signed [XY_W-1:0] ay_ext;
    logic signed [XY_W-1:0] az_ext;
    logic [71:0]            mag_sum;
    logic signed [Z_W-1:0]  ang_sum;
    logic signed [17:0]     ang_q;
    logic [19:0]            mag_sat;
    logic [14:0]            ang_sat;

    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);

    // angle wrap and half-plane fold on the incoming roll
    always_comb begin
        theta   = {{2{i_s_axis_tdata[31]}}, i_s_axis_tdata[31:16], 14'd0};
        theta_w = theta;
        if (theta > DEG_180) begin
            theta_w = theta - DEG_360;
        end else if (theta < -DEG_180) begin
            theta_w = theta + DEG_360;
        end
        flip    = 1'b0;
        theta_f = theta_w;
        if (theta_w > DEG_90) begin
            theta_f = theta_w - DEG_180;
            flip    = 1'b1;
        end else if (theta_w < -DEG_90) begin
            theta_f = theta_w + DEG_180;
            flip    = 1'b1;
        end
        prod_mk = $signed(i_s_axis_tdata[15:0]) * $signed({1'b0, K_Q30});
        rx_full = flip ? -XY_W'(prod_mk) : XY_W'(prod_mk);
    end

    // rounding of chain results, zero-vector test, and magnitude and angle rounding and saturation
    always_comb begin
        ty       = 24'((chain_out.x + XY_W'(64'sd8388608)) >>> 24);
        tz       = 24'((chain_out.y + XY_W'(64'sd8388608)) >>> 24);
        ay_ext   = XY_W'(r_ay);
        az_ext   = XY_W'(r_az);
        vec_zero = (r_ay == '0) && (r_az == '0);
        mag_sum  = (72'(r_phi) << 24) + 72'(r_plo) + (72'd1 << 37);
        mag_sat  = (mag_sum[71:38] > 34'd1048575) ? 20'hFFFFF : mag_sum[57:38];
        ang_sum  = r_vz + 32'sd8192;
        ang_q    = 18'(ang_sum >>> 14);
        if (ang_q > 18'sd11520) begin
            ang_sat = 15'sd11520;
        end else if (ang_q < -18'sd11520) begin
            ang_sat = -15'sd11520;
        end else begin
            ang_sat = ang_q[14:0];
        end
    end

    // chain feed
    always_comb begin
        chain_in.valid = 1'b0;
        chain_in.vec   = 1'b0;
        chain_in.x     = r_x0;
        chain_in.y     = '0;
        chain_in.z     = r_z0;
        if (r_state == ST_LAUNCH) begin
            chain_in.valid = 1'b1;
        end else if (r_state == ST_VLAUNCH && !vec_zero) begin
            chain_in.valid = 1'b1;
            chain_in.vec   = 1'b1;
            chain_in.x     = ay_ext;
            chain_in.y     = az_ext;
            chain_in.z     = '0;
            if (ay_ext < 0) begin
                chain_in.x = -ay_ext;
                chain_in.y = -az_ext;
                chain_in.z = (az_ext >= 0) ? DEG_180 : -DEG_180;
            end
        end
    end

    pdvc_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (chain_in),
        .o_data  (chain_out)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (in_acc) n_state = ST_LAUNCH;
            ST_LAUNCH:  n_state = ST_ROT;
            ST_ROT:     if (chain_out.valid) n_state = ST_GAIN;
            ST_GAIN:    n_state = ST_VLAUNCH;
            ST_VLAUNCH: n_state = vec_zero ? ST_DONE : ST_VEC;
            ST_VEC:     if (chain_out.valid) n_state = ST_MAG1;
            ST_MAG1:    n_state = ST_MAG2;
            ST_MAG2:    n_state = ST_DONE;
            ST_DONE:    if (!r_out_valid) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers and kept components
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_z <= 16'sd4096;
            r_gain_y <= 16'sd4096;
            r_prev_y <= '0;
            r_prev_z <= '0;
        end else begin
            if (i_cfg_we && i_cfg_addr == CFG_GAIN_Z) r_gain_z <= i_cfg_data;
            if (i_cfg_we && i_cfg_addr == CFG_GAIN_Y) r_gain_y <= i_cfg_data;
            if (r_state == ST_ROT && chain_out.valid) begin
                r_prev_y <= ty;
                r_prev_z <= tz;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x0 <= rx_full;
            r_z0 <= theta_f;
        end
        if (r_state == ST_ROT && chain_out.valid) begin
            r_dy <= 25'(ty) - 25'(r_prev_y);
            r_dz <= 25'(tz) - 25'(r_prev_z);
        end
        if (r_state == ST_GAIN) begin
            r_ay <= r_dy * r_gain_y;
            r_az <= r_dz * r_gain_z;
        end
        if (r_state == ST_VLAUNCH && vec_zero) begin
            r_res_mag <= '0;
            r_res_ang <= '0;
        end
        if (r_state == ST_VEC && chain_out.valid) begin
            r_vx <= chain_out.x;
            r_vz <= chain_out.z;
        end
        if (r_state == ST_MAG1) begin
            r_plo <= r_vx[23:0] * K_Q20;
            r_phi <= r_vx[47:24] * K_Q20;
        end
        if (r_state == ST_MAG2) begin
            r_res_mag <= mag_sat;
            r_res_ang <= ang_sat;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && !r_out_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && !r_out_valid) begin
            r_out_mag <= r_res_mag;
            r_out_ang <= r_res_ang;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_ang, r_out_mag};

    // chain results only appear while a pass is awaited
    a_chain_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain_out.valid |-> (r_state == ST_ROT || r_state == ST_VEC))
        else $error("chain result outside a pass");

    a_accept_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == ST_LAUNCH)
        else $error("accepted beat not launched");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($signed(r_out_ang) <= 15'sd11520 &&
                         $signed(r_out_ang) >= -15'sd11520))
        else $error("angle out of range");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !r_out_valid) |=> r_out_valid)
        else $error("result not loaded");

endmodule
